FILE: sv/udd_pkg.sv
// Shared types and constants for the ultrasonic echo distance block.
// No dependencies; every other file in sv/ imports this package.
package udd_pkg;

    localparam int SENSOR_W    = 2;
    localparam int TICK_W      = 16;
    localparam int DIST_W      = 14;
    localparam int CFG_IDX_W   = 8;
    localparam int NUM_SENSORS = 4;

    localparam logic [TICK_W-1:0] PERIOD_RESET    = 16'd50000;
    localparam logic [TICK_W-1:0] MAX_TICKS_RESET = 16'd1160;
    localparam logic [TICK_W-1:0] ELAPSED_CAP     = 16'hFFFF;

    // distance = elapsed * 10 / 58 = floor(elapsed * (5 * ceil(2^24 / 29)) / 2^24),
    // exact for every 16-bit elapsed value.
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] DIST_RECIP = 22'd2892625;
    localparam int PROD_W      = TICK_W + RECIP_W;
    localparam logic [DIST_W-1:0]  DIST_MAX   = 14'd11299;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TICKS    = 8'd1;

    typedef struct packed {
        logic [TICK_W-1:0] timer_period;
        logic [TICK_W-1:0] max_ticks;
    } t_cfg;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor;
        logic [TICK_W-1:0]   elapsed;
        logic                ok;
    } t_job;

endpackage

FILE: sv/udd_front.sv
// Front end: takes edge beats, keeps the per-sensor start counts and turns
// each falling edge into a measurement job. Depends on udd_pkg.
module udd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  udd_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [udd_pkg::SENSOR_W-1:0] i_sensor,
    input  logic                         i_level,
    input  logic [udd_pkg::TICK_W-1:0]   i_timer_count,
    input  logic                         i_q_full,
    output logic                         o_push,
    output udd_pkg::t_job                o_job
);
    import udd_pkg::*;

    logic [TICK_W-1:0] r_start [NUM_SENSORS];
    logic [TICK_W-1:0] start;
    logic [TICK_W:0]   up;
    logic [TICK_W:0]   wrap_diff;
    logic [TICK_W-1:0] elapsed;
    logic              ok;
    logic              in_range;
    logic              accept;

    // Rising edges never need queue space.
    assign o_ready  = i_level | ~i_q_full;
    assign accept   = i_valid & o_ready;
    assign in_range = int'(i_sensor) < NUM_SENSORS;
    assign start    = r_start[i_sensor];

    assign up        = {1'b0, i_cfg.timer_period} + {1'b0, i_timer_count};
    assign wrap_diff = up - {1'b0, start};

    always_comb begin
        elapsed = '0;
        ok      = 1'b0;
        if (i_timer_count > start) begin
            elapsed = i_timer_count - start;
            ok      = elapsed < i_cfg.max_ticks;
        end else if (i_timer_count < start) begin
            if (up >= {1'b0, start}) begin
                elapsed = wrap_diff[TICK_W] ? ELAPSED_CAP : wrap_diff[TICK_W-1:0];
                ok      = 1'b1;
            end
        end
    end

    assign o_push      = accept & ~i_level & in_range;
    assign o_job.sensor  = i_sensor;
    assign o_job.elapsed = elapsed;
    assign o_job.ok      = ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SENSORS; k++) begin
                r_start[k] <= '0;
            end
        end else if (accept && i_level && in_range) begin
            r_start[i_sensor] <= i_timer_count;
        end
    end

endmodule

FILE: sv/udd_fifo.sv
// Two-entry job queue between the front end and the distance pipeline.
// Depends on udd_pkg for the job type.
module udd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  udd_pkg::t_job i_job,
    input  logic          i_pop,
    output udd_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import udd_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_job   = r_mem[r_rptr];
    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("job popped from empty queue");

endmodule

FILE: sv/udd_back.sv
// Back end: pops jobs, scales elapsed ticks to distance with a reciprocal
// multiply and holds the result beat. Depends on udd_pkg.
module udd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  udd_pkg::t_job                i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [udd_pkg::SENSOR_W-1:0] o_sensor_out,
    output logic [udd_pkg::DIST_W-1:0]   o_distance,
    output logic                         o_valid_res
);
    import udd_pkg::*;

    logic                r_p_valid;
    logic [SENSOR_W-1:0] r_p_sensor;
    logic                r_p_ok;
    logic [PROD_W-1:0]   r_p_prod;
    logic                r_o_valid;
    logic [SENSOR_W-1:0] r_o_sensor;
    logic [DIST_W-1:0]   r_o_dist;
    logic                r_o_ok;
    logic                adv;

    // Advance the whole pipe whenever the output slot is free or drains.
    assign adv   = ~r_o_valid | i_ready;
    assign o_pop = adv & ~i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_p_valid <= ~i_q_empty;
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_sensor <= i_job.sensor;
            r_p_ok     <= i_job.ok;
            r_p_prod   <= PROD_W'(i_job.elapsed) * PROD_W'(DIST_RECIP);
            r_o_sensor <= r_p_sensor;
            r_o_ok     <= r_p_ok;
            r_o_dist   <= r_p_ok ? r_p_prod[RECIP_SHIFT +: DIST_W] : '0;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_sensor_out = r_o_sensor;
    assign o_distance   = r_o_dist;
    assign o_valid_res  = r_o_ok;

endmodule

FILE: sv/ultrasonic_echo_distance.sv
// Ultrasonic echo distance meter, top level. A falling-edge beat passes through
// the job queue, the product register and the output register to its result
// beat; rising edges give no result. Throughput: one edge beat per cycle unless
// a falling edge meets a full two-entry job queue; the multiply pipe has two stages.
// Reset (synchronous, active low) clears start counts, queue and valids and
// loads timer_period = 50000 and max_ticks = 1160. Uses udd_pkg and submodules.
module ultrasonic_echo_distance (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // edge beats
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [udd_pkg::SENSOR_W-1:0]  i_sensor,
    input  logic                          i_level,
    input  logic [udd_pkg::TICK_W-1:0]    i_timer_count,
    // result beats
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [udd_pkg::SENSOR_W-1:0]  o_sensor_out,
    output logic [udd_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_valid_res,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [udd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [udd_pkg::TICK_W-1:0]    i_cfg_data
);
    import udd_pkg::*;

    t_cfg r_cfg;
    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // Register writes are always accepted; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timer_period <= PERIOD_RESET;
            r_cfg.max_ticks    <= MAX_TICKS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TIMER_PERIOD: r_cfg.timer_period <= i_cfg_data;
                REG_MAX_TICKS:    r_cfg.max_ticks    <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // Front: classify edges, hold start counts, compute elapsed ticks.
    udd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_sensor      (i_sensor),
        .i_level       (i_level),
        .i_timer_count (i_timer_count),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    // Queue: decouple the front from output backpressure.
    udd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: scale to distance and hold the result beat.
    udd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_job        (pop_job),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_sensor_out (o_sensor_out),
        .o_distance   (o_distance),
        .o_valid_res  (o_valid_res)
    );

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |-> o_distance == '0)
        else $error("invalid result carries nonzero distance");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_distance <= DIST_MAX)
        else $error("distance beyond saturated range");

    a_rising_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> i_in_valid && o_in_ready && !i_level)
        else $error("job queued without an accepted falling edge");

endmodule

FILE: tb/sv/ultrasonic_echo_distance_tb.sv
// Self-checking testbench for ultrasonic_echo_distance: edge beats in, distance beats out.
// Holds its own predictor of the pulse timing in a small scoreboard class.
// Depends on udd_pkg and the RTL top level only.
`timescale 1ns / 100ps

module ultrasonic_echo_distance_tb;
    import udd_pkg::*;

    // distance = ticks * DIST_NUM / DIST_DEN
    localparam int unsigned DIST_NUM      = 10;
    localparam int unsigned DIST_DEN      = 58;
    localparam int unsigned TICK_TOP      = 65535;
    localparam int unsigned RESET_CYCLES  = 12;
    // extra wait after the last expected beat; leave margin
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned RANDOM_EDGES  = 850;
    localparam int unsigned PHASE_EDGES   = 110;
    localparam int unsigned RUN_LIMIT_NS  = 3_000_000;
    // first index above the defined registers; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_MAX_TICKS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor;
        logic [DIST_W-1:0]   distance;
        logic                measured;
    } t_echo_result;

    // Tracks pulse start counts and register values; queues the distance beat that
    // each falling edge must produce and checks arriving beats against it.
    class echo_scoreboard;
        t_echo_result      expected_q[$];
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] max_ticks;
        logic [TICK_W-1:0] start_count [NUM_SENSORS];
        int unsigned       errors;

        function new();
            errors    = 0;
            period    = PERIOD_RESET;
            max_ticks = MAX_TICKS_RESET;
            foreach (start_count[k]) start_count[k] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [TICK_W-1:0] data);
            if (index == REG_TIMER_PERIOD) period = data;
            else if (index == REG_MAX_TICKS) max_ticks = data;
        endfunction

        function void note_edge(logic [SENSOR_W-1:0] sensor, logic level,
                                logic [TICK_W-1:0] now);
            int unsigned  start;
            int unsigned  up;
            int unsigned  ticks;
            t_echo_result res;
            if (sensor >= NUM_SENSORS) return;
            if (level) begin
                start_count[sensor] = now;
                return;
            end
            start        = start_count[sensor];
            ticks        = 0;
            res.measured = 1'b0;
            if (now > start) begin
                ticks        = now - start;
                res.measured = (ticks < max_ticks);
            end else if (now < start) begin
                // timer wrapped: no width limit, but a start beyond the period is bogus
                up = period + now;
                if (up >= start) begin
                    ticks = up - start;
                    if (ticks > ELAPSED_CAP) ticks = ELAPSED_CAP;
                    res.measured = 1'b1;
                end
            end
            res.sensor   = sensor;
            res.distance = res.measured ? DIST_W'((ticks * DIST_NUM) / DIST_DEN) : '0;
            expected_q.push_back(res);
        endfunction

        function void check_result(t_echo_result got);
            t_echo_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected distance beat: sensor_out %0d distance %0d valid_res %0d",
                       got.sensor, got.distance, got.measured);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.sensor !== want.sensor) begin
                $error("sensor_out: expected %0d, got %0d", want.sensor, got.sensor);
                errors++;
            end
            if (got.distance !== want.distance) begin
                $error("distance: expected %0d, got %0d", want.distance, got.distance);
                errors++;
            end
            if (got.measured !== want.measured) begin
                $error("valid_res: expected %0d, got %0d", want.measured, got.measured);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic [SENSOR_W-1:0]  i_sensor      = '0;
    logic                 i_level       = 1'b0;
    logic [TICK_W-1:0]    i_timer_count = '0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [SENSOR_W-1:0]  o_sensor_out;
    logic [DIST_W-1:0]    o_distance;
    logic                 o_valid_res;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [TICK_W-1:0]    i_cfg_data    = '0;

    echo_scoreboard sb;
    // steady flags switch off the random gaps for a whole phase
    bit             in_steady  = 1'b0;
    bit             out_steady = 1'b0;
    int unsigned    edges_sent = 0;

    ultrasonic_echo_distance dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sensor      (i_sensor),
        .i_level       (i_level),
        .i_timer_count (i_timer_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sensor_out  (o_sensor_out),
        .o_distance    (o_distance),
        .o_valid_res   (o_valid_res),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Send one edge beat. Hold valid and payload until accepted; drop valid only
    // when a gap is drawn, so a back-to-back beat keeps valid high.
    task automatic send_edge(input logic [SENSOR_W-1:0] sensor, input logic level,
                             input logic [TICK_W-1:0] count);
        int unsigned gap;
        gap = in_steady ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_sensor      <= sensor;
        i_level       <= level;
        i_timer_count <= count;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_edge(sensor, level, count);
        edges_sent++;
    endtask

    task automatic send_pulse(input logic [SENSOR_W-1:0] sensor,
                              input logic [TICK_W-1:0] start, input logic [TICK_W-1:0] stop);
        send_edge(sensor, 1'b1, start);
        send_edge(sensor, 1'b0, stop);
    endtask

    // Register write; only called while no distance beat is outstanding.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [TICK_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(index, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop the edge valid and wait until every expected beat has arrived, then let
    // the pipe drain past any trailing rising edge.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [TICK_W-1:0] pick_setting(logic [TICK_W-1:0] home);
        case ($urandom_range(0, 3))
            0:       return 16'd1;
            1:       return TICK_W'(TICK_TOP);
            2:       return home;
            default: return TICK_W'($urandom);
        endcase
    endfunction

    // One well-formed pulse with random content: a count that grew (biased to the
    // width limit), a wrapped count (biased to the sane side of the period), or equal
    // counts. Now and then a stray edge lands inside the pulse.
    task automatic random_pulse();
        logic [SENSOR_W-1:0] sensor;
        int unsigned         start;
        int unsigned         stop;
        int unsigned         width;
        int unsigned         limit;
        int unsigned         hi;
        int unsigned         kind;
        sensor = $urandom_range(0, NUM_SENSORS - 1);
        kind   = $urandom_range(0, 9);
        if (kind < 5) begin
            limit = sb.max_ticks;
            case ($urandom_range(0, 3))
                0:       width = limit - 1;
                1:       width = limit;
                2:       width = limit + 1;
                default: width = $urandom_range(1, (2 * limit > TICK_TOP) ? TICK_TOP : 2 * limit);
            endcase
            if (width == 0) width = 1;
            if (width > TICK_TOP) width = TICK_TOP;
            start = $urandom_range(0, TICK_TOP - width);
            stop  = start + width;
        end else if (kind < 9) begin
            stop = $urandom_range(0, TICK_TOP - 1);
            hi   = TICK_TOP;
            if ($urandom_range(0, 1) != 0) begin
                hi = sb.period + stop;
                if (hi > TICK_TOP) hi = TICK_TOP;
            end
            start = $urandom_range(stop + 1, hi);
        end else begin
            start = $urandom_range(0, TICK_TOP);
            stop  = start;
        end
        send_edge(sensor, 1'b1, TICK_W'(start));
        if ($urandom_range(0, 7) == 0)
            send_edge(SENSOR_W'($urandom), 1'b1, TICK_W'($urandom));
        send_edge(sensor, 1'b0, TICK_W'(stop));
    endtask

    // Result side: draw a stall per beat, then hold ready until a beat is taken.
    initial begin
        t_echo_result got;
        int unsigned  stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = out_steady ? 0 : $urandom_range(0, 9);
            @(negedge i_clk);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.sensor   = o_sensor_out;
            got.distance = o_distance;
            got.measured = o_valid_res;
            sb.check_result(got);
        end
    end

    initial begin
        int unsigned phase_goal;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: period 50000, limit 1160.
        send_edge(2'd0, 1'b0, 16'd0);              // fall with no rise: equal counts
        send_edge(2'd1, 1'b0, 16'd100);            // fall against the reset start of zero
        send_pulse(2'd2, 16'd1000, 16'd2159);      // one tick under the limit
        send_pulse(2'd2, 16'd1000, 16'd2160);      // exactly at the limit: invalid
        send_pulse(2'd3, 16'd49000, 16'd500);      // wrap through the period
        send_pulse(2'd0, 16'hFFFF, 16'hFFFF);      // equal counts at the top
        settle();

        write_reg(REG_UNUSED_LO, 16'h1234);        // unknown index: drop it
        write_reg(REG_TIMER_PERIOD, 16'd1);
        write_reg(REG_MAX_TICKS, 16'hFFFF);
        send_pulse(2'd1, 16'hFFFF, 16'd0);         // wrap with start beyond the period
        send_pulse(2'd1, 16'd0, 16'hFFFF);         // widest grown count, at the limit
        send_pulse(2'd3, 16'd1, 16'hFFFF);         // widest valid grown count
        settle();

        write_reg(REG_TIMER_PERIOD, 16'hFFFF);
        write_reg(REG_MAX_TICKS, 16'd1);
        send_pulse(2'd2, 16'hFFFF, 16'hFFFE);      // longest wrap
        send_pulse(2'd0, 16'd5, 16'd6);            // one tick against a limit of one
        send_edge(2'd1, 1'b1, 16'd123);
        send_edge(2'd1, 1'b1, 16'd200);            // second rise re-arms the start
        send_edge(2'd1, 1'b0, 16'd100);

        // Random phases, each under fresh register values.
        edges_sent = 0;
        while (edges_sent < RANDOM_EDGES) begin
            settle();
            write_reg(REG_TIMER_PERIOD, pick_setting(PERIOD_RESET));
            write_reg(REG_MAX_TICKS, pick_setting(MAX_TICKS_RESET));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                          TICK_W'($urandom));
            in_steady  = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
            phase_goal = edges_sent + PHASE_EDGES;
            while (edges_sent < phase_goal && edges_sent < RANDOM_EDGES) begin
                if ($urandom_range(0, 6) == 0)
                    send_edge(SENSOR_W'($urandom), 1'($urandom), TICK_W'($urandom));
                else
                    random_pulse();
                // hold the sender until the result side has caught up
                if ($urandom_range(0, 59) == 0)
                    settle();
            end
        end

        in_steady  = 1'b0;
        out_steady = 1'b0;
        settle();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $error("run did not finish in time");
        $display("status: fail");
        $finish;
    end

endmodule
